FILE: src/ipv6_route_table_lpm_macros.svh
// assertion helpers for the route table
`ifndef IPV6_ROUTE_TABLE_LPM_MACROS_SVH
`define IPV6_ROUTE_TABLE_LPM_MACROS_SVH

// condition a at an edge demands c at the same edge
`define RT_ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("route table check failed");

// condition a at an edge demands c at the next edge
`define RT_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("route table check failed");

`endif

FILE: src/ipv6rt_pkg.sv
package ipv6rt_pkg;

	localparam int DEPTH = 32;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [7:0]  MAX_LEN        = 8'd128;
	localparam logic [15:0] DEFAULT_METRIC = 16'd10;
	localparam logic [1:0]  SRC_MANUAL     = 2'd0;
	localparam logic [1:0]  SRC_RA         = 2'd1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	localparam logic REG_DIST_CONN   = 1'b0;
	localparam logic REG_DIST_STATIC = 1'b1;

	typedef enum logic [1:0] {
		FN_LOOKUP = 2'd0,
		FN_STATIC = 2'd1,
		FN_PREFIX = 2'd2,
		FN_DELETE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC
	} fsm_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_PREV,
		CELL_NEXT,
		CELL_UPD
	} cell_op_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  prefix_len;
		logic [15:0] metric_in;
		logic [7:0]  iface_in;
		logic [63:0] hop_hi;
		logic [63:0] hop_lo;
		logic [31:0] expiry_in;
		logic [1:0]  source_kind;
		logic [31:0] now_tick;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  iface_out;
		logic [63:0] next_hi;
		logic [63:0] next_lo;
		logic [7:0]  match_len;
		logic [5:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic [63:0] pfx_hi;
		logic [63:0] pfx_lo;
		logic [7:0]  len;
		logic [7:0]  adm_dist;
		logic [15:0] metric;
		logic [7:0]  iface;
		logic [63:0] nh_hi;
		logic [63:0] nh_lo;
		logic [31:0] expiry;
		logic [1:0]  src;
	} route_t;

	// broadcast to every cell for one transaction
	typedef struct packed {
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [31:0] now;
		logic [1:0]  src;
	} qry_t;

	typedef struct packed {
		logic hit;
		logic rm;
		logic better;
		logic same;
	} cell_flg_t;

endpackage

FILE: src/ipv6rt_cell.sv
module ipv6rt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ipv6rt_pkg::cell_op_t op,
	input  ipv6rt_pkg::route_t   new_ent,
	input  ipv6rt_pkg::qry_t     qry,
	input  ipv6rt_pkg::route_t   prev_ent,
	input  logic                 prev_vld,
	input  ipv6rt_pkg::route_t   next_ent,
	input  logic                 next_vld,
	output ipv6rt_pkg::route_t   ent,
	output logic                 vld,
	output ipv6rt_pkg::cell_flg_t flg
);

	ipv6rt_pkg::route_t ent_q;
	ipv6rt_pkg::route_t upd_ent;
	logic               vld_q;
	logic [63:0]        mhi;
	logic [63:0]        mlo;
	logic [7:0]         lo_len;
	logic               match;
	logic               expired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (op)
				ipv6rt_pkg::CELL_LOAD: vld_q <= 1'b1;
				ipv6rt_pkg::CELL_PREV: vld_q <= prev_vld;
				ipv6rt_pkg::CELL_NEXT: vld_q <= next_vld;
				default: vld_q <= vld_q;
			endcase
		end
	end

	always_comb begin
		upd_ent        = ent_q;
		upd_ent.iface  = new_ent.iface;
		upd_ent.expiry = new_ent.expiry;
	end

	always_ff @(posedge clk) begin
		case (op)
			ipv6rt_pkg::CELL_LOAD: ent_q <= new_ent;
			ipv6rt_pkg::CELL_PREV: ent_q <= prev_ent;
			ipv6rt_pkg::CELL_NEXT: ent_q <= next_ent;
			ipv6rt_pkg::CELL_UPD:  ent_q <= upd_ent;
			default: ent_q <= ent_q;
		endcase
	end

	always_comb begin
		lo_len = ent_q.len - 8'd64;
		mhi = (ent_q.len >= 8'd64) ? '1 : ~({64{1'b1}} >> ent_q.len);
		mlo = (ent_q.len <= 8'd64) ? '0 : ~({64{1'b1}} >> lo_len);
		match = (((qry.addr_hi ^ ent_q.pfx_hi) & mhi) == '0)
			&& (((qry.addr_lo ^ ent_q.pfx_lo) & mlo) == '0);
		expired = (ent_q.expiry != '0) && (qry.now > ent_q.expiry);
		flg.hit = vld_q && match && !expired;
		flg.rm  = vld_q && match && expired && (ent_q.src == ipv6rt_pkg::SRC_RA);
		if (new_ent.len != ent_q.len)
			flg.better = vld_q && (new_ent.len > ent_q.len);
		else if (new_ent.adm_dist != ent_q.adm_dist)
			flg.better = vld_q && (new_ent.adm_dist < ent_q.adm_dist);
		else
			flg.better = vld_q && (new_ent.metric < ent_q.metric);
		flg.same = vld_q && (ent_q.src == qry.src) && (ent_q.pfx_hi == qry.addr_hi)
			&& (ent_q.pfx_lo == qry.addr_lo) && (ent_q.len == new_ent.len);
	end

	assign ent = ent_q;
	assign vld = vld_q;

endmodule

FILE: src/ipv6_route_table_lpm.sv
// IPv6 route table with longest-prefix lookup, held in a chain of 32 route cells kept
// sorted by longer prefix, then lower distance, then lower metric. Every cell compares
// its route against the request at once; inserts and deletes shift the cells by one
// toward a neighbor. Add, update and delete are accepted, then executed into the result
// register once the output can take it. A lookup first removes each expired
// router-advertisement route that matches ahead of the found route, by one shift of the
// chain each. A new request is taken while a finished result still waits at the output.
`include "ipv6_route_table_lpm_macros.svh"

module ipv6_route_table_lpm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  ipv6rt_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output ipv6rt_pkg::rsp_t   rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int D = ipv6rt_pkg::DEPTH;

	ipv6rt_pkg::fsm_t     state_q, state_n;
	ipv6rt_pkg::req_t     req_q, req_c;
	ipv6rt_pkg::rsp_t     rsp_q, rsp_n;
	logic                 rsp_vld_q;
	logic [7:0]           dist_conn_q, dist_static_q;
	logic [ipv6rt_pkg::CNT_W-1:0] cnt_q, cnt_n;

	ipv6rt_pkg::route_t    new_ent;
	ipv6rt_pkg::qry_t      qry;
	ipv6rt_pkg::route_t    ent_w [D];
	ipv6rt_pkg::cell_flg_t flg_w [D];
	ipv6rt_pkg::cell_op_t  op_w  [D];
	logic [D-1:0] vld_v, hit_v, rm_v, bet_v, same_v;
	logic [D-1:0] hit_oh, rm_elig, rm_oh, ins_x, ins_oh, same_oh, before_hit;
	logic [D-1:0] m_load, m_prev, m_next, m_upd;
	ipv6rt_pkg::route_t hit_ent;
	logic         do_rm, go, finish, full, accept;
	logic [7:0]   plen_c;
	logic [15:0]  metric_c;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ipv6rt_pkg::S_IDLE);
	assign pready    = 1'b1;

	assign plen_c = (req.prefix_len > ipv6rt_pkg::MAX_LEN) ? ipv6rt_pkg::MAX_LEN
		: req.prefix_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_conn_q   <= 8'd0;
			dist_static_q <= 8'd1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				ipv6rt_pkg::REG_DIST_CONN:   dist_conn_q   <= pwdata[7:0];
				ipv6rt_pkg::REG_DIST_STATIC: dist_static_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ipv6rt_pkg::REG_DIST_CONN:   prdata = {24'd0, dist_conn_q};
			ipv6rt_pkg::REG_DIST_STATIC: prdata = {24'd0, dist_static_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		req_c            = req;
		req_c.prefix_len = plen_c;
	end

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req_c;
	end

	// route a new or updated entry would carry
	always_comb begin
		metric_c = (req_q.metric_in == '0) ? ipv6rt_pkg::DEFAULT_METRIC : req_q.metric_in;
		new_ent.pfx_hi = req_q.addr_hi;
		new_ent.pfx_lo = req_q.addr_lo;
		new_ent.len    = req_q.prefix_len;
		new_ent.iface  = req_q.iface_in;
		if (req_q.func == ipv6rt_pkg::FN_STATIC) begin
			new_ent.adm_dist = dist_static_q;
			new_ent.metric   = metric_c;
			new_ent.nh_hi    = req_q.hop_hi;
			new_ent.nh_lo    = req_q.hop_lo;
			new_ent.expiry   = '0;
			new_ent.src      = ipv6rt_pkg::SRC_MANUAL;
		end else begin
			new_ent.adm_dist = dist_conn_q;
			new_ent.metric   = '0;
			new_ent.nh_hi    = '0;
			new_ent.nh_lo    = '0;
			new_ent.expiry   = req_q.expiry_in;
			new_ent.src      = req_q.source_kind;
		end
		qry.addr_hi = req_q.addr_hi;
		qry.addr_lo = req_q.addr_lo;
		qry.now     = req_q.now_tick;
		qry.src     = (req_q.func == ipv6rt_pkg::FN_DELETE) ? ipv6rt_pkg::SRC_RA
			: req_q.source_kind;
	end

	for (genvar i = 0; i < D; i++) begin : g_cell
		ipv6rt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op_w[i]),
			.new_ent  (new_ent),
			.qry      (qry),
			.prev_ent ((i == 0) ? ent_w[0] : ent_w[(i == 0) ? 0 : i - 1]),
			.prev_vld ((i == 0) ? 1'b0 : vld_v[(i == 0) ? 0 : i - 1]),
			.next_ent ((i == D - 1) ? ent_w[D - 1] : ent_w[(i == D - 1) ? i : i + 1]),
			.next_vld ((i == D - 1) ? 1'b0 : vld_v[(i == D - 1) ? i : i + 1]),
			.ent      (ent_w[i]),
			.vld      (vld_v[i]),
			.flg      (flg_w[i])
		);
		assign hit_v[i]  = flg_w[i].hit;
		assign rm_v[i]   = flg_w[i].rm;
		assign bet_v[i]  = flg_w[i].better;
		assign same_v[i] = flg_w[i].same;
	end

	always_comb begin
		hit_oh     = hit_v & (~hit_v + 1'b1);
		before_hit = (hit_oh == '0) ? '1 : (hit_oh - 1'b1);
		rm_elig    = rm_v & before_hit;
		rm_oh      = rm_elig & (~rm_elig + 1'b1);
		ins_x      = bet_v | ~vld_v;
		ins_oh     = ins_x & (~ins_x + 1'b1);
		same_oh    = same_v & (~same_v + 1'b1);
		full       = vld_v[D-1];
		hit_ent    = '0;
		for (int i = 0; i < D; i++) begin
			if (hit_oh[i])
				hit_ent = hit_ent | ent_w[i];
		end
	end

	assign go     = !rsp_vld_q || !rsp_stall;
	assign do_rm  = (state_q == ipv6rt_pkg::S_EXEC) && (req_q.func == ipv6rt_pkg::FN_LOOKUP)
		&& (rm_elig != '0);
	assign finish = (state_q == ipv6rt_pkg::S_EXEC) && !do_rm && go;

	always_comb begin
		m_load = '0;
		m_prev = '0;
		m_next = '0;
		m_upd  = '0;
		cnt_n  = cnt_q;
		rsp_n  = '0;
		rsp_n.status = ipv6rt_pkg::STATUS_OK;
		if (do_rm) begin
			m_next = ~(rm_oh - 1'b1);
			cnt_n  = cnt_q - 1'b1;
		end else if (finish) begin
			case (req_q.func)
				ipv6rt_pkg::FN_LOOKUP: begin
					if (hit_oh == '0) begin
						rsp_n.status = ipv6rt_pkg::STATUS_MISS;
					end else begin
						rsp_n.iface_out = hit_ent.iface;
						rsp_n.next_hi   = hit_ent.nh_hi;
						rsp_n.next_lo   = hit_ent.nh_lo;
						rsp_n.match_len = hit_ent.len;
					end
				end
				ipv6rt_pkg::FN_DELETE: begin
					if (same_oh == '0) begin
						rsp_n.status = ipv6rt_pkg::STATUS_MISS;
					end else begin
						m_next = ~(same_oh - 1'b1);
						cnt_n  = cnt_q - 1'b1;
					end
				end
				default: begin
					if (req_q.func == ipv6rt_pkg::FN_PREFIX && same_oh != '0) begin
						m_upd = same_oh;
					end else if (full) begin
						rsp_n.status = ipv6rt_pkg::STATUS_FULL;
					end else begin
						m_load = ins_oh;
						m_prev = ~(ins_oh - 1'b1) & ~ins_oh;
						cnt_n  = cnt_q + 1'b1;
					end
				end
			endcase
		end
		rsp_n.entry_count = 6'(cnt_n);
		for (int i = 0; i < D; i++) begin
			if (m_load[i])
				op_w[i] = ipv6rt_pkg::CELL_LOAD;
			else if (m_prev[i])
				op_w[i] = ipv6rt_pkg::CELL_PREV;
			else if (m_next[i])
				op_w[i] = ipv6rt_pkg::CELL_NEXT;
			else if (m_upd[i])
				op_w[i] = ipv6rt_pkg::CELL_UPD;
			else
				op_w[i] = ipv6rt_pkg::CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipv6rt_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ipv6rt_pkg::S_IDLE: if (req_valid) state_n = ipv6rt_pkg::S_EXEC;
			ipv6rt_pkg::S_EXEC: if (finish) state_n = ipv6rt_pkg::S_IDLE;
			default: state_n = ipv6rt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			cnt_q <= cnt_n;
			if (finish)
				rsp_vld_q <= 1'b1;
			else if (!rsp_stall)
				rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish)
			rsp_q <= rsp_n;
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// valid cells always form a run from the head of the chain
	`RT_ASSERT_NOW(a_vld_contig, clk, arst_n, 1'b1, ((vld_v + 1'b1) & vld_v) == '0)
	`RT_ASSERT_NOW(a_cnt_match, clk, arst_n, 1'b1, $countones(vld_v) == int'(cnt_q))
	`RT_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == ipv6rt_pkg::S_EXEC)
	`RT_ASSERT_NOW(a_one_shift, clk, arst_n, 1'b1, $onehot0(m_load | m_upd))

endmodule
